// ===== rtl/strd_pkg.sv =====
// Shared types and constants of the score trend detector.
package strd_pkg;

	typedef logic signed [15:0] score_t;
	typedef logic [15:0]        gap_t;
	typedef logic [15:0]        cfg_val_t;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_UP   = 2'd1,
		ACT_DOWN = 2'd2
	} action_t;

	// register index, taken from paddr[2]
	localparam logic REG_HYSTERESIS = 1'b0;
	localparam logic REG_MIN_GAP    = 1'b1;

	localparam cfg_val_t HYST_RESET    = 16'd10;
	localparam cfg_val_t MIN_GAP_RESET = 16'd500;

endpackage

// ===== rtl/strd_if.sv =====
// Valid/ready channel interfaces for samples and decisions.
interface strd_in_if;
	logic           valid;
	logic           ready;
	strd_pkg::score_t score;
	strd_pkg::gap_t   gap_ms;

	modport source(output valid, score, gap_ms, input ready);
	modport sink(input valid, score, gap_ms, output ready);
endinterface

interface strd_out_if;
	logic              valid;
	logic              ready;
	strd_pkg::action_t action;

	modport source(output valid, action, input ready);
	modport sink(input valid, action, output ready);
endinterface

// ===== rtl/score_trend_detector.sv =====
// Top level: moving-average crossover detector on a score stream.
//
//  channel    dir   payload                     handshake
//  sample     in    score (s16), gap_ms (u16)   valid/ready
//  decision   out   action (2 bit)              valid/ready
//  apb        cfg   hysteresis, min_gap_ms      psel/penable, pready tied high
//
// One item per clock when decision.ready stays high. The accepting edge sets
// s1_valid, and decision.valid follows as the registered out_valid_q. The
// throughput is set by the window update (shift line plus running sum), done
// in the accepting cycle, and the registered compare stage after it.
// Async active-low reset clears fills, sums, valids and registers; the sample
// lines are not reset and are read only once their window is full.
// A stalled decision holds the compare stage, which then drops sample.ready.
module score_trend_detector #(
	parameter int SHORT_LEN = 3,
	parameter int LONG_LEN  = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	strd_in_if.sink             sample,
	strd_out_if.source          decision,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	// sum widths: N samples of 16 bits need 16 + clog2(N)
	localparam int SSUM_W  = 16 + $clog2(SHORT_LEN);
	localparam int LSUM_W  = 16 + $clog2(LONG_LEN);
	localparam int SFILL_W = $clog2(SHORT_LEN + 1);
	localparam int LFILL_W = $clog2(LONG_LEN + 1);
	// product of both lengths scales the threshold
	localparam int PROD    = SHORT_LEN * LONG_LEN;
	// |LONG*ssum - SHORT*lsum| <= PROD * 2^16, plus sign
	localparam int DIFF_W  = 18 + $clog2(PROD);
	localparam int THR_W   = 16 + $clog2(PROD + 1);

	localparam logic [SFILL_W-1:0] SHORT_FULL_CNT = SFILL_W'(SHORT_LEN);
	localparam logic [LFILL_W-1:0] LONG_FULL_CNT  = LFILL_W'(LONG_LEN);

	// ---------------- configuration port ----------------
	strd_pkg::cfg_val_t hyst_q;
	strd_pkg::cfg_val_t min_gap_q;
	logic [THR_W-1:0]   thr_q;       // PROD * hysteresis, kept ready for compare
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hyst_q    <= strd_pkg::HYST_RESET;
			min_gap_q <= strd_pkg::MIN_GAP_RESET;
			thr_q     <= THR_W'(PROD) * THR_W'(strd_pkg::HYST_RESET);
		end else if (cfg_wr) begin
			if (paddr[2] == strd_pkg::REG_HYSTERESIS) begin
				hyst_q <= pwdata[15:0];
				thr_q  <= THR_W'(PROD) * THR_W'(pwdata[15:0]);
			end else begin
				min_gap_q <= pwdata[15:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == strd_pkg::REG_MIN_GAP) begin
			prdata = {16'd0, min_gap_q};
		end else begin
			prdata = {16'd0, hyst_q};
		end
	end

	// ---------------- handshake ----------------
	logic             s1_valid;
	logic             gate_s1;       // gap exceeded and both windows full
	logic             out_valid_q;
	strd_pkg::action_t action_q;
	logic             s1_adv;
	logic             accept;

	assign s1_adv       = !out_valid_q || decision.ready;
	assign sample.ready = !s1_valid || s1_adv;
	assign accept       = sample.valid && sample.ready;

	// ---------------- window update (accepting cycle) ----------------
	// Each window is a shift line: newest at tap 0, oldest at the last tap.
	strd_pkg::score_t         short_line_q [SHORT_LEN];
	strd_pkg::score_t         long_line_q  [LONG_LEN];
	logic signed [SSUM_W-1:0] short_sum_q;
	logic signed [LSUM_W-1:0] long_sum_q;
	logic [SFILL_W-1:0]       short_fill_q;
	logic [LFILL_W-1:0]       long_fill_q;
	logic                     short_full;
	logic                     long_full;
	logic                     short_full_nxt;
	logic                     long_full_nxt;
	logic signed [SSUM_W-1:0] short_drop;
	logic signed [LSUM_W-1:0] long_drop;

	assign short_full     = (short_fill_q == SHORT_FULL_CNT);
	assign long_full      = (long_fill_q == LONG_FULL_CNT);
	assign short_full_nxt = short_full || (short_fill_q == SHORT_FULL_CNT - 1'b1);
	assign long_full_nxt  = long_full || (long_fill_q == LONG_FULL_CNT - 1'b1);
	// oldest sample leaves the sum only once the window is full
	assign short_drop = short_full ? SSUM_W'(short_line_q[SHORT_LEN-1]) : '0;
	assign long_drop  = long_full ? LSUM_W'(long_line_q[LONG_LEN-1]) : '0;

	always_ff @(posedge clk) begin
		if (accept) begin
			short_line_q[0] <= sample.score;
			long_line_q[0]  <= sample.score;
			for (int i = 1; i < SHORT_LEN; i++) begin
				short_line_q[i] <= short_line_q[i-1];
			end
			for (int i = 1; i < LONG_LEN; i++) begin
				long_line_q[i] <= long_line_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_sum_q  <= '0;
			long_sum_q   <= '0;
			short_fill_q <= '0;
			long_fill_q  <= '0;
			s1_valid     <= 1'b0;
			gate_s1      <= 1'b0;
		end else begin
			if (accept) begin
				short_sum_q <= short_sum_q + SSUM_W'(sample.score) - short_drop;
				long_sum_q  <= long_sum_q + LSUM_W'(sample.score) - long_drop;
				if (!short_full) begin
					short_fill_q <= short_fill_q + 1'b1;
				end
				if (!long_full) begin
					long_fill_q <= long_fill_q + 1'b1;
				end
				gate_s1 <= (sample.gap_ms > min_gap_q) && short_full_nxt && long_full_nxt;
			end
			if (accept) begin
				s1_valid <= 1'b1;
			end else if (s1_adv) begin
				s1_valid <= 1'b0;
			end
		end
	end

	// ---------------- compare stage ----------------
	// The sums already include the item in stage 1; they cannot move before
	// it leaves, since a held stage 1 blocks the next accept.
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]        mag;
	strd_pkg::action_t        action_nxt;

	assign diff = DIFF_W'(LONG_LEN) * DIFF_W'(short_sum_q)
	            - DIFF_W'(SHORT_LEN) * DIFF_W'(long_sum_q);
	assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

	always_comb begin
		action_nxt = strd_pkg::ACT_NONE;
		if (gate_s1 && (mag >= DIFF_W'(thr_q))) begin
			// zero difference with zero hysteresis counts as down
			action_nxt = (!diff[DIFF_W-1] && (diff != '0)) ? strd_pkg::ACT_UP
			                                               : strd_pkg::ACT_DOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			action_q    <= strd_pkg::ACT_NONE;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid;
			action_q    <= action_nxt;
		end
	end

	assign decision.valid  = out_valid_q;
	assign decision.action = action_q;

	// ---------------- checks ----------------
	a_no_gate_no_action: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && s1_adv && !gate_s1) |=> (action_q == strd_pkg::ACT_NONE))
		else $error("action raised without gap or full windows");

	a_full_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && long_full) |=> $stable(long_fill_q))
		else $error("long fill moved past full");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (s1_valid && out_valid_q && !decision.ready))
		else $error("sample stalled without a held decision");

	a_gate_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && gate_s1) |-> (short_full && long_full))
		else $error("decision gate open with a window not full");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for score_trend_detector: scoreboard, APB and stream drivers.
module tb_top;

	localparam int SHORT_WIN = 3;
	localparam int LONG_WIN  = 10;

	// register byte addresses, index taken from bit 2
	localparam logic [2:0] ADDR_HYST    = {strd_pkg::REG_HYSTERESIS, 2'b00};
	localparam logic [2:0] ADDR_MIN_GAP = {strd_pkg::REG_MIN_GAP, 2'b00};

	localparam int ITEMS_PER_PHASE = 200;
	localparam int RANDOM_PHASES   = 7;

	// expected decisions in flight; a handful at most
	localparam int WANT_DEPTH = 16;

	// ------------------------------------------------------------------
	// Scoreboard: its own copy of both windows and of the registers.
	// Each accepted sample is pushed through the windows and the expected
	// decision is stored; each accepted decision is checked against the
	// oldest entry.
	// ------------------------------------------------------------------
	class trend_scoreboard;
		strd_pkg::cfg_val_t hysteresis;
		strd_pkg::cfg_val_t min_gap;
		longint   short_ring [SHORT_WIN];
		longint   long_ring [LONG_WIN];
		longint   short_sum;
		longint   long_sum;
		int       short_fill;
		int       long_fill;
		int       short_slot;
		int       long_slot;
		strd_pkg::action_t want_fifo [WANT_DEPTH];
		int       want_rd;
		int       want_wr;
		int       want_cnt;
		int       errors;

		function new();
			hysteresis = strd_pkg::HYST_RESET;
			min_gap    = strd_pkg::MIN_GAP_RESET;
			short_sum  = 0;
			long_sum   = 0;
			short_fill = 0;
			long_fill  = 0;
			short_slot = 0;
			long_slot  = 0;
			want_rd    = 0;
			want_wr    = 0;
			want_cnt   = 0;
			errors     = 0;
		endfunction

		// only the low 16 bits of a write are kept
		function void write_reg(logic idx, logic [31:0] data);
			if (idx == strd_pkg::REG_HYSTERESIS)
				hysteresis = data[15:0];
			else
				min_gap = data[15:0];
		endfunction

		function void push_sample(strd_pkg::score_t s, strd_pkg::gap_t g);
			longint  v;
			longint  d;
			longint  mag;
			longint  thr;
			strd_pkg::action_t act;
			v = longint'(s);

			// short window: drop the oldest once full
			if (short_fill == SHORT_WIN)
				short_sum -= short_ring[short_slot];
			else
				short_fill++;
			short_ring[short_slot] = v;
			short_sum += v;
			short_slot = (short_slot == SHORT_WIN - 1) ? 0 : short_slot + 1;

			// long window, same scheme
			if (long_fill == LONG_WIN)
				long_sum -= long_ring[long_slot];
			else
				long_fill++;
			long_ring[long_slot] = v;
			long_sum += v;
			long_slot = (long_slot == LONG_WIN - 1) ? 0 : long_slot + 1;

			act = strd_pkg::ACT_NONE;
			if (g > min_gap && short_fill == SHORT_WIN && long_fill == LONG_WIN) begin
				// averages compared with both sides scaled by the other window length
				d   = longint'(LONG_WIN) * short_sum - longint'(SHORT_WIN) * long_sum;
				mag = (d < 0) ? -d : d;
				thr = longint'(SHORT_WIN * LONG_WIN) * longint'(hysteresis);
				if (mag >= thr)
					act = (d > 0) ? strd_pkg::ACT_UP : strd_pkg::ACT_DOWN;
			end
			want_fifo[want_wr] = act;
			want_wr = (want_wr == WANT_DEPTH - 1) ? 0 : want_wr + 1;
			want_cnt++;
		endfunction

		function void check_action(strd_pkg::action_t got);
			strd_pkg::action_t want;
			if (want_cnt == 0) begin
				$display("%0t: action mismatch: expected none, actual %s",
					$time, got.name());
				errors++;
			end else begin
				want = want_fifo[want_rd];
				want_rd = (want_rd == WANT_DEPTH - 1) ? 0 : want_rd + 1;
				want_cnt--;
				if (got !== want) begin
					$display("%0t: action mismatch: expected %s, actual %s",
						$time, want.name(), got.name());
					errors++;
				end
			end
		endfunction

		function int pending();
			return want_cnt;
		endfunction
	endclass

	// ------------------------------------------------------------------
	// Clock, channels, block
	// ------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	strd_in_if  samples ();
	strd_out_if decisions ();

	trend_scoreboard sb;

	// no idling on either side once set (closing phase)
	bit quiet = 1'b0;
	int stall_left = 0;

	// random walk that feeds the windows with trends and reversals
	int level = 0;
	int drift = 40;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	score_trend_detector #(
		.SHORT_LEN(SHORT_WIN),
		.LONG_LEN (LONG_WIN)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (samples),
		.decision(decisions),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// ------------------------------------------------------------------
	// Monitors: sampled at the rising edge, values from before the edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && samples.valid && samples.ready)
			sb.push_sample(samples.score, samples.gap_ms);
	end

	always @(posedge clk) begin
		if (arst_n && decisions.valid && decisions.ready)
			sb.check_action(decisions.action);
	end

	// Receiver: ready drops in random bursts, never while quiet.
	always @(negedge clk) begin
		if (!quiet && stall_left == 0 && $urandom_range(0, 4) == 0)
			stall_left = $urandom_range(1, 3);
		if (stall_left > 0) begin
			decisions.ready <= 1'b0;
			stall_left--;
		end else begin
			decisions.ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// One sample item; an idle burst may come first. Returns at the
	// accepting edge, with valid still high.
	task automatic send_sample(strd_pkg::score_t s, strd_pkg::gap_t g);
		int idle;
		idle = 0;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 5) == 0)
			idle = $urandom_range(1, 3);
		if (idle > 0) begin
			samples.valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		samples.valid  <= 1'b1;
		samples.score  <= s;
		samples.gap_ms <= g;
		do @(posedge clk); while (!samples.ready);
	endtask

	// Lower valid and wait for every outstanding decision.
	task automatic drain();
		@(negedge clk);
		samples.valid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
	endtask

	// APB write: setup, access; taken at the edge between (pready is high).
	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.write_reg(addr[2], data);
	endtask

	// APB read, low half compared with the value last written
	task automatic reg_check(logic [2:0] addr, strd_pkg::cfg_val_t want);
		logic [31:0] got;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got[15:0] !== want) begin
			$display("%0t: register %0d read mismatch: expected %0d, actual %0d",
				$time, addr, want, got[15:0]);
			sb.errors++;
		end
	endtask

	// Both registers, with junk in the upper bits that must be dropped.
	task automatic configure(strd_pkg::cfg_val_t hyst, strd_pkg::cfg_val_t gap);
		reg_write(ADDR_HYST, {16'($urandom), hyst});
		reg_write(ADDR_MIN_GAP, {16'($urandom), gap});
		reg_check(ADDR_HYST, hyst);
		reg_check(ADDR_MIN_GAP, gap);
	endtask

	// ------------------------------------------------------------------
	// Stimulus generators
	// ------------------------------------------------------------------

	// Mostly a drifting walk so the averages cross; some raw and extreme values.
	function automatic strd_pkg::score_t next_score();
		int r;
		int noise;
		r = $urandom_range(0, 99);
		if (r < 10)
			return strd_pkg::score_t'($urandom);
		if (r < 15)
			return $urandom_range(0, 1) ? strd_pkg::score_t'(16'h7fff)
			                            : strd_pkg::score_t'(16'h8000);
		if ($urandom_range(0, 30) == 0)
			drift = int'($urandom_range(0, 400)) - 200;
		noise = int'($urandom_range(0, 200)) - 100;
		level = level + drift + noise;
		if (level > 32767) begin
			level = 32767;
			drift = -40;
		end else if (level < -32768) begin
			level = -32768;
			drift = 40;
		end
		return strd_pkg::score_t'(level);
	endfunction

	// Gap mostly just above the threshold, else at, below, or at the rails.
	function automatic strd_pkg::gap_t next_gap(strd_pkg::cfg_val_t min_gap);
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 55)
			v = int'(min_gap) + 1 + int'($urandom_range(0, 800));
		else if (r < 75)
			v = int'($urandom_range(0, min_gap));
		else if (r < 80)
			v = int'(min_gap);
		else if (r < 90)
			v = int'($urandom_range(0, 65535));
		else if (r < 95)
			v = 0;
		else
			v = 65535;
		if (v > 65535)
			v = 65535;
		return strd_pkg::gap_t'(v);
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		strd_pkg::cfg_val_t hyst;
		strd_pkg::cfg_val_t gap;

		sb = new();
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		samples.valid   = 1'b0;
		samples.score   = '0;
		samples.gap_ms  = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// --- directed, reset settings (hysteresis 10, gap 500) ---
		// fill both windows at the positive rail; action stays none until both are
		// full, then equal averages stay inside the hysteresis
		repeat (10) send_sample(strd_pkg::score_t'(16'h7fff), strd_pkg::gap_t'(16'hffff));
		// drop to the negative rail: short average falls below long
		send_sample(strd_pkg::score_t'(16'h8000), strd_pkg::gap_t'(16'hffff));
		// gap equal to the threshold does not exceed it
		send_sample(strd_pkg::score_t'(16'h8000), strd_pkg::gap_t'(500));
		send_sample(strd_pkg::score_t'(16'h8000), strd_pkg::gap_t'(501));
		send_sample(strd_pkg::score_t'(16'h7fff), strd_pkg::gap_t'(0));
		send_sample(strd_pkg::score_t'(16'h7fff), strd_pkg::gap_t'(501));
		send_sample(strd_pkg::score_t'(16'h7fff), strd_pkg::gap_t'(1000));
		send_sample(strd_pkg::score_t'(0), strd_pkg::gap_t'(16'h5555));
		send_sample(strd_pkg::score_t'(-1), strd_pkg::gap_t'(16'haaaa));
		send_sample(strd_pkg::score_t'(16'h5555), strd_pkg::gap_t'(16'hffff));
		send_sample(strd_pkg::score_t'(16'haaaa), strd_pkg::gap_t'(16'hffff));
		drain();

		// --- directed, hysteresis zero and gap zero ---
		// constant samples give equal averages, which then read as down
		configure(16'd0, 16'd0);
		repeat (10) send_sample(strd_pkg::score_t'(100), strd_pkg::gap_t'(1));
		// gap zero never exceeds a zero threshold
		send_sample(strd_pkg::score_t'(100), strd_pkg::gap_t'(0));
		drain();

		// --- random phases over a spread of settings ---
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					hyst = 16'd0;
					gap  = 16'd0;
				end
				1: begin
					hyst = 16'hffff;
					gap  = 16'hffff;
				end
				2: begin
					hyst = 16'hffff;
					gap  = 16'd0;
				end
				3: begin
					hyst = strd_pkg::cfg_val_t'($urandom_range(0, 65535));
					gap  = strd_pkg::cfg_val_t'($urandom_range(0, 65535));
				end
				4: begin
					hyst = 16'd1;
					gap  = strd_pkg::cfg_val_t'($urandom_range(0, 1000));
				end
				5: begin
					hyst = strd_pkg::cfg_val_t'($urandom_range(0, 300));
					gap  = strd_pkg::cfg_val_t'($urandom_range(0, 2000));
				end
				default: begin
					hyst = strd_pkg::HYST_RESET;
					gap  = strd_pkg::MIN_GAP_RESET;
				end
			endcase
			configure(hyst, gap);
			// closing phase runs flat out on both sides
			if (ph == RANDOM_PHASES - 1)
				quiet = 1'b1;
			repeat (ITEMS_PER_PHASE) send_sample(next_score(), next_gap(gap));
			drain();
		end

		// allow for any stray decision after the last expected one
		repeat (8) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#5000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== score_trend_detector.f =====
rtl/strd_pkg.sv
rtl/strd_if.sv
rtl/score_trend_detector.sv
tb/sv/tb_top.sv
